// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bcfs_pkg.sv
// ----------------------------------------------------------------------------
// bcfs_pkg
// Commands, status codes and fixed field widths of the linked-block file store.
// ----------------------------------------------------------------------------
package bcfs_pkg;

    localparam int DVW = 18;   // dividend width (length or position)
    localparam int TW  = 19;   // block count width

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_RESIZE = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SLOT  = 2'd1;
    localparam logic [1:0] ST_NO_BLOCK = 2'd2;
    localparam logic [1:0] ST_PAST     = 2'd3;

    localparam logic [1:0] WM_LEN  = 2'd0;
    localparam logic [1:0] WM_CUT  = 2'd1;
    localparam logic [1:0] WM_BYTE = 2'd2;

    localparam logic REG_BLOCKS = 1'b0;
    localparam logic REG_FILES  = 1'b1;

    localparam logic [7:0] BYTE_RESET = 8'h20;

endpackage

// File: src/block_chain_file_store.sv
// ----------------------------------------------------------------------------
// block_chain_file_store
// File store over a linked block table, one command per beat, one result beat.
// ----------------------------------------------------------------------------
// After reset the block sweeps all its memories, one byte-store address a
// cycle, and takes no beat until done. Each command then runs on one
// sequencer over tables with registered reads: the length or position is
// split into block number and offset by a shift and a mask as the beat is
// taken (BLOCK_BYTES must be a power of two), then each table access is a
// read state followed by a check state. A chain walk, the free-block count
// over the active range, the first-fit allocation and a cut all step one
// block at a time this way. One command is in flight at a time; the next is
// taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module block_chain_file_store
    import bcfs_pkg::*;
#(
    parameter int BLOCK_BYTES = 512,
    parameter int NUM_BLOCKS  = 256,
    parameter int NUM_FILES   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [4:0]  file_index,
    input  logic [17:0] length_bytes,
    input  logic [16:0] byte_pos,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [4:0]  file_slot_out,
    output logic [7:0]  read_data,
    output logic [17:0] size_now
);

    localparam int BW    = $clog2(NUM_BLOCKS);
    localparam int LW    = BW + 1;
    localparam int FIW   = $clog2(NUM_FILES);
    localparam int CW    = $clog2(NUM_BLOCKS + 1);
    localparam int TOTAL = NUM_BLOCKS * BLOCK_BYTES;
    localparam int AW    = $clog2(TOTAL);
    localparam int CLR   = (TOTAL > NUM_FILES) ? TOTAL : NUM_FILES;
    localparam int SCW   = $clog2(CLR + 1);
    localparam int OW    = $clog2(BLOCK_BYTES);

    localparam logic [LW-1:0] LINK_FREE = '1;
    localparam logic [LW-1:0] LINK_END  = {{(LW-1){1'b1}}, 1'b0};

    localparam logic [4:0] S_CLEAR      = 5'd0;
    localparam logic [4:0] S_IDLE       = 5'd1;
    localparam logic [4:0] S_DISP       = 5'd3;
    localparam logic [4:0] S_SLOT_RD    = 5'd4;
    localparam logic [4:0] S_SLOT_CHK   = 5'd5;
    localparam logic [4:0] S_FT_RD      = 5'd6;
    localparam logic [4:0] S_FT_CHK     = 5'd7;
    localparam logic [4:0] S_WALK_RD    = 5'd8;
    localparam logic [4:0] S_WALK_CHK   = 5'd9;
    localparam logic [4:0] S_DECIDE     = 5'd10;
    localparam logic [4:0] S_CNT_RD     = 5'd11;
    localparam logic [4:0] S_CNT_CHK    = 5'd12;
    localparam logic [4:0] S_CNT_END    = 5'd13;
    localparam logic [4:0] S_ALLOC_RD   = 5'd14;
    localparam logic [4:0] S_ALLOC_CHK  = 5'd15;
    localparam logic [4:0] S_ALLOC_END  = 5'd16;
    localparam logic [4:0] S_CUT_RD     = 5'd17;
    localparam logic [4:0] S_CUT_CHK    = 5'd18;
    localparam logic [4:0] S_RESIZE_FIN = 5'd19;
    localparam logic [4:0] S_BADDR      = 5'd20;
    localparam logic [4:0] S_BWR        = 5'd21;
    localparam logic [4:0] S_BRD_RD     = 5'd22;
    localparam logic [4:0] S_BRD_CHK    = 5'd23;
    localparam logic [4:0] S_DONE       = 5'd24;
    localparam logic [4:0] S_CREATE_FIN = 5'd25;

    // memories
    logic [LW-1:0]  link_mem  [NUM_BLOCKS];
    logic [LW-1:0]  first_mem [NUM_FILES];
    logic [17:0]    size_mem  [NUM_FILES];
    logic [7:0]     byte_mem  [TOTAL];
    logic [LW-1:0]  link_rd_reg;
    logic [LW-1:0]  first_rd_reg;
    logic [17:0]    size_rd_reg;
    logic [7:0]     byte_rd_reg;

    logic           link_we;
    logic [BW-1:0]  link_wa;
    logic [LW-1:0]  link_wd;
    logic [BW-1:0]  link_ra;
    logic           first_we;
    logic           size_we;
    logic [FIW-1:0] file_wa;
    logic [LW-1:0]  first_wd;
    logic [17:0]    size_wd;
    logic [FIW-1:0] file_ra;
    logic           byte_we;
    logic [AW-1:0]  byte_wa;
    logic [7:0]     byte_wd;

    // config
    logic [8:0]     blocks_in_use_reg;
    logic [5:0]     files_in_use_reg;
    logic           cfg_write;

    // sequencer
    logic [4:0]     state_reg, state_next;
    logic [1:0]     cmd_reg, cmd_next;
    logic [4:0]     fi_reg, fi_next;
    logic [17:0]    len_reg, len_next;
    logic [16:0]    pos_reg, pos_next;
    logic [7:0]     wdata_reg, wdata_next;
    logic [DVW-1:0] q_reg, q_next;
    logic [OW-1:0]  rem_reg, rem_next;
    logic [SCW-1:0] scan_reg, scan_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [CW-1:0]  have_reg, have_next;
    logic [CW-1:0]  hops_reg, hops_next;
    logic [TW-1:0]  tgt_reg, tgt_next;
    logic [1:0]     mode_reg, mode_next;
    logic [BW-1:0]  cur_reg, cur_next;
    logic [BW-1:0]  prev_reg, prev_next;
    logic           has_prev_reg, has_prev_next;
    logic [BW-1:0]  first_reg, first_next;
    logic           cut_first_reg, cut_first_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [1:0]     st_reg, st_next;
    logic [4:0]     slot_reg, slot_next;
    logic [7:0]     rd_reg, rd_next;
    logic [17:0]    size_reg, size_next;

    // result register
    logic           out_valid_reg, out_valid_next;
    logic [1:0]     status_reg, status_next;
    logic [4:0]     slot_out_reg, slot_out_next;
    logic [7:0]     rdata_out_reg, rdata_out_next;
    logic [17:0]    size_out_reg, size_out_next;

    logic [TW-1:0]  need;
    logic           scan_in_blocks;
    logic           scan_in_files;
    logic           link_is_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_FILES) ? 32'(files_in_use_reg)
                                               : 32'(blocks_in_use_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= 9'd256;
            files_in_use_reg  <= 6'd32;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_BLOCKS)
            begin
                blocks_in_use_reg <= pwdata[8:0];
            end
            else
            begin
                files_in_use_reg <= pwdata[5:0];
            end
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign file_slot_out = slot_out_reg;
    assign read_data     = rdata_out_reg;
    assign size_now      = size_out_reg;

    assign need  = TW'(q_reg) + TW'((rem_reg != '0) || (q_reg == '0));
    assign scan_in_blocks = (32'(scan_reg) < 32'(blocks_in_use_reg))
                            && (32'(scan_reg) < NUM_BLOCKS);
    assign scan_in_files  = (32'(scan_reg) < 32'(files_in_use_reg))
                            && (32'(scan_reg) < NUM_FILES);
    assign link_is_next   = (32'(link_rd_reg) < NUM_BLOCKS);

    // memories
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd_reg <= link_mem[link_ra];
    end

    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[file_wa] <= first_wd;
        end
        if (size_we)
        begin
            size_mem[file_wa] <= size_wd;
        end
        first_rd_reg <= first_mem[file_ra];
        size_rd_reg  <= size_mem[file_ra];
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_wa] <= byte_wd;
        end
        byte_rd_reg <= byte_mem[addr_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        fi_next        = fi_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        wdata_next     = wdata_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        scan_next      = scan_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        have_next      = have_reg;
        hops_next      = hops_reg;
        tgt_next       = tgt_reg;
        mode_next      = mode_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        has_prev_next  = has_prev_reg;
        first_next     = first_reg;
        cut_first_next = cut_first_reg;
        addr_next      = addr_reg;
        st_next        = st_reg;
        slot_next      = slot_reg;
        rd_next        = rd_reg;
        size_next      = size_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        slot_out_next  = slot_out_reg;
        rdata_out_next = rdata_out_reg;
        size_out_next  = size_out_reg;

        link_we  = 1'b0;
        link_wa  = cur_reg;
        link_wd  = LINK_FREE;
        link_ra  = cur_reg;
        first_we = 1'b0;
        size_we  = 1'b0;
        file_wa  = FIW'(fi_reg);
        first_wd = LINK_FREE;
        size_wd  = '0;
        file_ra  = FIW'(fi_reg);
        byte_we  = 1'b0;
        byte_wa  = addr_reg;
        byte_wd  = wdata_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                link_wa  = scan_reg[BW-1:0];
                link_we  = (32'(scan_reg) < NUM_BLOCKS);
                file_wa  = scan_reg[FIW-1:0];
                first_we = (32'(scan_reg) < NUM_FILES);
                size_we  = (32'(scan_reg) < NUM_FILES);
                byte_wa  = scan_reg[AW-1:0];
                byte_wd  = BYTE_RESET;
                byte_we  = (32'(scan_reg) < TOTAL);
                scan_next = scan_reg + 1'b1;
                if (32'(scan_reg) == CLR - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = command;
                    fi_next      = file_index;
                    len_next     = length_bytes;
                    pos_next     = byte_pos;
                    wdata_next   = write_data;
                    q_next       = command[1] ? DVW'(byte_pos >> OW)
                                              : DVW'(length_bytes >> OW);
                    rem_next     = command[1] ? byte_pos[OW-1:0]
                                              : length_bytes[OW-1:0];
                    st_next      = ST_OK;
                    slot_next    = file_index;
                    rd_next      = '0;
                    size_next    = '0;
                    state_next   = S_DISP;
                end
            end
            S_DISP:
            begin
                if (cmd_reg == CMD_CREATE)
                begin
                    scan_next  = '0;
                    slot_next  = '0;
                    state_next = S_SLOT_RD;
                end
                else if (32'(fi_reg) >= NUM_FILES)
                begin
                    st_next    = ST_PAST;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FT_RD;
                end
            end
            S_SLOT_RD:
            begin
                file_ra = scan_reg[FIW-1:0];
                if (scan_in_files)
                begin
                    state_next = S_SLOT_CHK;
                end
                else
                begin
                    st_next    = ST_NO_SLOT;
                    state_next = S_DONE;
                end
            end
            S_SLOT_CHK:
            begin
                if (first_rd_reg == LINK_FREE)
                begin
                    slot_next  = 5'(scan_reg);
                    state_next = S_DECIDE;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SLOT_RD;
                end
            end
            S_FT_RD:
            begin
                state_next = S_FT_CHK;
            end
            S_FT_CHK:
            begin
                if (first_rd_reg == LINK_FREE)
                begin
                    st_next    = ST_PAST;
                    state_next = S_DONE;
                end
                else
                begin
                    size_next  = size_rd_reg;
                    first_next = BW'(first_rd_reg);
                    cur_next   = BW'(first_rd_reg);
                    hops_next  = '0;
                    if (cmd_reg == CMD_READ)
                    begin
                        mode_next = WM_BYTE;
                        tgt_next  = TW'(q_reg);
                    end
                    else
                    begin
                        mode_next = WM_LEN;
                        tgt_next  = '1;
                    end
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                if (TW'(hops_reg) == tgt_reg)
                begin
                    if (mode_reg == WM_CUT)
                    begin
                        cut_first_next = 1'b1;
                        state_next     = S_CUT_RD;
                    end
                    else
                    begin
                        state_next = S_BADDR;
                    end
                end
                else
                begin
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (link_is_next)
                begin
                    cur_next   = BW'(link_rd_reg);
                    hops_next  = hops_reg + 1'b1;
                    state_next = S_WALK_RD;
                end
                else if (mode_reg == WM_LEN)
                begin
                    have_next     = hops_reg + 1'b1;
                    prev_next     = cur_reg;
                    has_prev_next = 1'b1;
                    state_next    = S_DECIDE;
                end
                else
                begin
                    st_next    = ST_PAST;
                    state_next = S_DONE;
                end
            end
            S_DECIDE:
            begin
                scan_next = '0;
                cnt_next  = '0;
                case (cmd_reg)
                    CMD_CREATE:
                    begin
                        has_prev_next = 1'b0;
                        n_next        = CW'(need);
                        if (32'(need) > NUM_BLOCKS)
                        begin
                            st_next    = ST_NO_BLOCK;
                            slot_next  = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_CNT_RD;
                        end
                    end
                    CMD_RESIZE:
                    begin
                        n_next = CW'(need - TW'(have_reg));
                        if (need > TW'(have_reg))
                        begin
                            if (32'(need) > NUM_BLOCKS)
                            begin
                                st_next    = ST_NO_BLOCK;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_CNT_RD;
                            end
                        end
                        else if (need < TW'(have_reg))
                        begin
                            cur_next   = first_reg;
                            hops_next  = '0;
                            tgt_next   = need - 1'b1;
                            mode_next  = WM_CUT;
                            state_next = S_WALK_RD;
                        end
                        else
                        begin
                            state_next = S_RESIZE_FIN;
                        end
                    end
                    default:
                    begin
                        n_next = CW'(TW'(q_reg) + 1'b1 - TW'(have_reg));
                        if (q_reg >= DVW'(have_reg))
                        begin
                            if (32'(q_reg) >= NUM_BLOCKS)
                            begin
                                st_next    = ST_NO_BLOCK;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_CNT_RD;
                            end
                        end
                        else
                        begin
                            cur_next   = first_reg;
                            hops_next  = '0;
                            tgt_next   = TW'(q_reg);
                            mode_next  = WM_BYTE;
                            state_next = S_WALK_RD;
                        end
                    end
                endcase
            end
            S_CNT_RD:
            begin
                link_ra = scan_reg[BW-1:0];
                state_next = scan_in_blocks ? S_CNT_CHK : S_CNT_END;
            end
            S_CNT_CHK:
            begin
                if (link_rd_reg == LINK_FREE)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                scan_next  = scan_reg + 1'b1;
                state_next = S_CNT_RD;
            end
            S_CNT_END:
            begin
                scan_next = '0;
                if (cnt_reg < n_reg)
                begin
                    st_next = ST_NO_BLOCK;
                    if (cmd_reg == CMD_CREATE)
                    begin
                        slot_next = '0;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ALLOC_RD;
                end
            end
            S_ALLOC_RD:
            begin
                link_ra    = scan_reg[BW-1:0];
                state_next = S_ALLOC_CHK;
            end
            S_ALLOC_CHK:
            begin
                link_wa    = prev_reg;
                link_wd    = LW'(scan_reg[BW-1:0]);
                scan_next  = scan_reg + 1'b1;
                state_next = S_ALLOC_RD;
                if (link_rd_reg == LINK_FREE)
                begin
                    if (has_prev_reg)
                    begin
                        link_we = 1'b1;
                    end
                    else
                    begin
                        first_next = scan_reg[BW-1:0];
                    end
                    prev_next     = scan_reg[BW-1:0];
                    has_prev_next = 1'b1;
                    n_next        = n_reg - 1'b1;
                    if (n_reg == CW'(1))
                    begin
                        state_next = S_ALLOC_END;
                    end
                end
            end
            S_ALLOC_END:
            begin
                link_we = 1'b1;
                link_wa = prev_reg;
                link_wd = LINK_END;
                case (cmd_reg)
                    CMD_CREATE:
                    begin
                        state_next = S_CREATE_FIN;
                    end
                    CMD_RESIZE:
                    begin
                        state_next = S_RESIZE_FIN;
                    end
                    default:
                    begin
                        cur_next   = first_reg;
                        hops_next  = '0;
                        tgt_next   = TW'(q_reg);
                        mode_next  = WM_BYTE;
                        state_next = S_WALK_RD;
                    end
                endcase
            end
            S_CREATE_FIN:
            begin
                file_wa    = FIW'(slot_reg);
                first_we   = 1'b1;
                first_wd   = LW'(first_reg);
                size_we    = 1'b1;
                size_wd    = '0;
                size_next  = '0;
                state_next = S_DONE;
            end
            S_CUT_RD:
            begin
                state_next = S_CUT_CHK;
            end
            S_CUT_CHK:
            begin
                link_we        = 1'b1;
                link_wd        = cut_first_reg ? LINK_END : LINK_FREE;
                cut_first_next = 1'b0;
                if (link_is_next)
                begin
                    cur_next   = BW'(link_rd_reg);
                    state_next = S_CUT_RD;
                end
                else
                begin
                    state_next = S_RESIZE_FIN;
                end
            end
            S_RESIZE_FIN:
            begin
                size_wd = len_reg;
                if (len_reg < size_reg)
                begin
                    size_we   = 1'b1;
                    size_next = len_reg;
                end
                state_next = S_DONE;
            end
            S_BADDR:
            begin
                addr_next  = AW'(AW'(cur_reg) * AW'(BLOCK_BYTES)) + AW'(rem_reg);
                state_next = (cmd_reg == CMD_WRITE) ? S_BWR : S_BRD_RD;
            end
            S_BWR:
            begin
                byte_we = 1'b1;
                size_wd = 18'(pos_reg) + 18'd1;
                if ((18'(pos_reg) + 18'd1) > size_reg)
                begin
                    size_we   = 1'b1;
                    size_next = 18'(pos_reg) + 18'd1;
                end
                state_next = S_DONE;
            end
            S_BRD_RD:
            begin
                state_next = S_BRD_CHK;
            end
            S_BRD_CHK:
            begin
                rd_next    = byte_rd_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    slot_out_next  = slot_reg;
                    rdata_out_next = rd_reg;
                    size_out_next  = size_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        fi_reg        <= fi_next;
        len_reg       <= len_next;
        pos_reg       <= pos_next;
        wdata_reg     <= wdata_next;
        q_reg         <= q_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        n_reg         <= n_next;
        have_reg      <= have_next;
        hops_reg      <= hops_next;
        tgt_reg       <= tgt_next;
        mode_reg      <= mode_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        has_prev_reg  <= has_prev_next;
        first_reg     <= first_next;
        cut_first_reg <= cut_first_next;
        addr_reg      <= addr_next;
        st_reg        <= st_next;
        slot_reg      <= slot_next;
        rd_reg        <= rd_next;
        size_reg      <= size_next;
        status_reg    <= status_next;
        slot_out_reg  <= slot_out_next;
        rdata_out_reg <= rdata_out_next;
        size_out_reg  <= size_out_next;
    end

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_starts_cmd, in_valid && !in_stall, state_reg == S_DISP, "accepted beat did not start a command")
    `ASSERT_IMPL(a_link_write_state, link_we, state_reg == S_CLEAR || state_reg == S_ALLOC_CHK || state_reg == S_ALLOC_END || state_reg == S_CUT_CHK, "link table written outside an allocating state")
    `ASSERT_IMPL(a_result_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE), "result beat raised outside completion")
    `ASSERT_IMPL(a_no_slot_is_create, state_reg == S_DONE && st_reg == ST_NO_SLOT, cmd_reg == CMD_CREATE, "no-slot status on a non-create command")

endmodule

// File: dv/tb_block_chain_file_store.sv
// ----------------------------------------------------------------------------
// tb_block_chain_file_store
// Self-checking bench for the linked-block file store.
// Commands go in through a valid/stall channel and results are checked beat by
// beat against an in-bench model of the link table, the file table and the
// byte store. The two range registers are set over the APB port between
// phases. The phases cover directed corner cases, random traffic under several
// idle/stall mixes, and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_block_chain_file_store;
    import bcfs_pkg::*;

    localparam int BLK_BYTES  = 512;
    localparam int NBLK       = 256;
    localparam int NFILES     = 32;
    localparam int LNK_FREE   = -1;
    localparam int LNK_END    = -2;
    localparam int NO_FIRST   = -1;
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int DRAIN_WAIT = 2200;
    localparam logic [2:0] ADDR_BLOCKS = {REG_BLOCKS, 2'b00};
    localparam logic [2:0] ADDR_FILES  = {REG_FILES, 2'b00};

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  file;
        logic [17:0] len;
        logic [16:0] pos;
        logic [7:0]  data;
    } fs_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [7:0]  rdata;
        logic [17:0] size;
    } fs_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = '0;
    logic [4:0]  file_index = '0;
    logic [17:0] length_bytes = '0;
    logic [16:0] byte_pos = '0;
    logic [7:0]  write_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [4:0]  file_slot_out;
    logic [7:0]  read_data;
    logic [17:0] size_now;

    block_chain_file_store i_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // model state
    int          link_tbl [NBLK];
    int          first_blk [NFILES];
    int          size_tbl [NFILES];
    logic [7:0]  byte_mem [NBLK*BLK_BYTES];
    int          cfg_blocks = 256;
    int          cfg_files = 32;

    fs_result_t  pending_results [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;

    function automatic int search_limit();
        return cfg_blocks < NBLK ? cfg_blocks : NBLK;
    endfunction

    function automatic int count_free();
        int n = 0;
        for (int i = 0; i < search_limit(); i++)
            if (link_tbl[i] == LNK_FREE)
                n++;
        return n;
    endfunction

    function automatic int alloc_block();
        for (int i = 0; i < search_limit(); i++)
            if (link_tbl[i] == LNK_FREE)
            begin
                link_tbl[i] = LNK_END;
                return i;
            end
        return 0;
    endfunction

    function automatic bit is_link(int v);
        return v >= 0 && v < NBLK;
    endfunction

    function automatic int chain_blocks(int first, output int tail);
        int n = 1;
        int b = first;
        while (is_link(link_tbl[b]) && n < NBLK)
        begin
            b = link_tbl[b];
            n++;
        end
        tail = b;
        return n;
    endfunction

    function automatic int nth_block(int first, int k);
        int b = first;
        for (int i = 0; i < k; i++)
        begin
            if (!is_link(link_tbl[b]))
                return -1;
            b = link_tbl[b];
        end
        return b;
    endfunction

    function automatic void extend_chain(int tail, int cnt);
        int nb;
        for (int i = 0; i < cnt; i++)
        begin
            nb = alloc_block();
            link_tbl[tail] = nb;
            tail = nb;
        end
    endfunction

    function automatic void free_after(int b);
        int steps = 0;
        int nx = link_tbl[b];
        int after;
        link_tbl[b] = LNK_END;
        while (is_link(nx) && steps < NBLK)
        begin
            after = link_tbl[nx];
            link_tbl[nx] = LNK_FREE;
            nx = after;
            steps++;
        end
    endfunction

    function automatic int blocks_needed(int len);
        int n = (len + BLK_BYTES - 1) / BLK_BYTES;
        return n == 0 ? 1 : n;
    endfunction

    function automatic fs_result_t apply_command(fs_cmd_t c);
        fs_result_t r;
        int fi = c.file;
        int len = c.len;
        int pos = c.pos;
        int need, have, tail, first, k, off, b, flim;
        bit found = 0;
        r = '0;
        r.slot = c.file;
        if (c.cmd == CMD_CREATE)
        begin
            flim = cfg_files < NFILES ? cfg_files : NFILES;
            need = blocks_needed(len);
            r.slot = '0;
            for (int i = 0; i < flim && !found; i++)
                if (first_blk[i] == NO_FIRST)
                begin
                    r.slot = 5'(i);
                    found = 1;
                end
            if (!found)
                r.status = ST_NO_SLOT;
            else if (need > NBLK || count_free() < need)
            begin
                r.status = ST_NO_BLOCK;
                r.slot = '0;
            end
            else
            begin
                first = alloc_block();
                extend_chain(first, need - 1);
                first_blk[r.slot] = first;
                size_tbl[r.slot] = 0;
            end
        end
        else if (first_blk[fi] == NO_FIRST)
            r.status = ST_PAST;
        else
        begin
            first = first_blk[fi];
            have = chain_blocks(first, tail);
            r.size = 18'(size_tbl[fi]);
            if (c.cmd == CMD_RESIZE)
            begin
                need = blocks_needed(len);
                if (need > have)
                begin
                    if (need > NBLK || count_free() < need - have)
                        r.status = ST_NO_BLOCK;
                    else
                        extend_chain(tail, need - have);
                end
                else if (need < have)
                    free_after(nth_block(first, need - 1));
                if (r.status == ST_OK && len < size_tbl[fi])
                begin
                    size_tbl[fi] = len;
                    r.size = 18'(len);
                end
            end
            else
            begin
                k = pos / BLK_BYTES;
                off = pos % BLK_BYTES;
                if (c.cmd == CMD_WRITE)
                begin
                    if (k >= have && (k >= NBLK || count_free() < k + 1 - have))
                        r.status = ST_NO_BLOCK;
                    else
                    begin
                        if (k >= have)
                            extend_chain(tail, k + 1 - have);
                        b = nth_block(first, k);
                        byte_mem[b*BLK_BYTES + off] = c.data;
                        if (pos + 1 > size_tbl[fi])
                        begin
                            size_tbl[fi] = pos + 1;
                            r.size = 18'(pos + 1);
                        end
                    end
                end
                else
                begin
                    b = nth_block(first, k);
                    if (b < 0)
                        r.status = ST_PAST;
                    else
                        r.rdata = byte_mem[b*BLK_BYTES + off];
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
                 field, got, want, cycle_count);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                fs_result_t e;
                e = pending_results.pop_front();
                if (status !== e.status)
                    report_mismatch("status", status, e.status);
                if (file_slot_out !== e.slot)
                    report_mismatch("file_slot_out", file_slot_out, e.slot);
                if (read_data !== e.rdata)
                    report_mismatch("read_data", read_data, e.rdata);
                if (size_now !== e.size)
                    report_mismatch("size_now", size_now, e.size);
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_beat(fs_cmd_t c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= c.cmd;
        file_index   <= c.file;
        length_bytes <= c.len;
        byte_pos     <= c.pos;
        write_data   <= c.data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_command(c));
    endtask

    task automatic send(logic [1:0] cmd, int file, int len, int pos, int data);
        fs_cmd_t c;
        c.cmd = cmd;
        c.file = 5'(file);
        c.len = 18'(len);
        c.pos = 17'(pos);
        c.data = 8'(data);
        send_beat(c);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_BLOCKS)
            cfg_blocks = value & 'h1FF;
        else
            cfg_files = value & 'h3F;
    endtask

    task automatic set_ranges(int blocks, int files);
        drain();
        apb_write(ADDR_BLOCKS, blocks);
        apb_write(ADDR_FILES, files);
    endtask

    task automatic random_beat();
        fs_cmd_t c;
        int sel = $urandom_range(99);
        c.data = 8'($urandom_range(255));
        c.file = 5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(7));
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: c.pos = 17'($urandom_range(1500));
            7, 8: c.pos = 17'($urandom_range(131071));
            default: c.pos = 17'(512 * $urandom_range(3) - $urandom_range(1));
        endcase
        case ($urandom_range(9))
            0: c.len = 18'($urandom_range(262143));
            1: c.len = 18'(512 * $urandom_range(4));
            default: c.len = 18'($urandom_range(3000));
        endcase
        if (sel < 10)
            c.cmd = CMD_CREATE;
        else if (sel < 25)
            c.cmd = CMD_RESIZE;
        else if (sel < 65)
            c.cmd = CMD_WRITE;
        else
            c.cmd = CMD_READ;
        send_beat(c);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        send(CMD_CREATE, 0, 0, 0, 0);
        send(CMD_CREATE, 0, 512, 0, 0);
        send(CMD_CREATE, 0, 513, 0, 0);
        send(CMD_CREATE, 0, 262143, 0, 0);
        send(CMD_WRITE, 0, 0, 511, 8'hFF);
        send(CMD_WRITE, 0, 0, 512, 8'h00);
        send(CMD_READ, 0, 0, 511, 0);
        send(CMD_READ, 0, 0, 512, 0);
        send(CMD_READ, 0, 0, 100, 0);
        send(CMD_READ, 0, 0, 1024, 0);
        send(CMD_WRITE, 31, 0, 3, 8'hA5);
        send(CMD_READ, 31, 0, 3, 0);
        send(CMD_RESIZE, 31, 100, 0, 0);
        send(CMD_RESIZE, 2, 0, 0, 0);
        send(CMD_RESIZE, 2, 2000, 0, 0);
        send(CMD_RESIZE, 1, 262143, 0, 0);
        send(CMD_WRITE, 1, 0, 131071, 8'h5A);
        send(CMD_CREATE, 0, 131072, 0, 0);
        send(CMD_RESIZE, 0, 10, 0, 0);
        send(CMD_READ, 0, 0, 511, 0);
    endtask

    task automatic test_range_limits();
        set_ranges(256, 3);
        send(CMD_CREATE, 0, 1, 0, 0);
        set_ranges(256, 0);
        send(CMD_CREATE, 0, 1, 0, 0);
        set_ranges(0, 32);
        send(CMD_CREATE, 0, 1, 0, 0);
        send(CMD_WRITE, 0, 0, 2000, 8'h11);
        set_ranges(1, 1);
        send(CMD_CREATE, 0, 1, 0, 0);
        send(CMD_RESIZE, 2, 0, 0, 0);
        send(CMD_RESIZE, 1, 0, 0, 0);
        send(CMD_RESIZE, 0, 0, 0, 0);
    endtask

    task automatic test_random_phase(int n, int idle, int stall, int blocks, int files);
        set_ranges(blocks, files);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            random_beat();
            if (i % 40 == 39)
                send(CMD_RESIZE, $urandom_range(7), $urandom_range(600), 0, 0);
        end
    endtask

    task automatic test_backpressure();
        drain();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 500;
        for (int i = 0; i < 8; i++)
            random_beat();
    endtask

    initial
    begin
        for (int i = 0; i < NBLK; i++)
            link_tbl[i] = LNK_FREE;
        for (int i = 0; i < NFILES; i++)
        begin
            first_blk[i] = NO_FIRST;
            size_tbl[i] = 0;
        end
        foreach (byte_mem[i])
            byte_mem[i] = BYTE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_range_limits();
        test_random_phase(170, 0, 0, 256, 32);
        test_random_phase(170, 60, 0, 37, 5);
        test_random_phase(120, 0, 60, 511, 63);
        test_random_phase(170, 11, 11, 256, 32);
        test_backpressure();
        test_random_phase(60, 60, 60, 1, 1);

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/bcfs_pkg.sv
src/block_chain_file_store.sv
dv/tb_block_chain_file_store.sv
